// ===== rtl/tank_level_gauge_filter_core_macros.svh =====
// Assertion macros used by the tank level gauge filter checker.
`ifndef TANK_LEVEL_GAUGE_FILTER_CORE_MACROS_SVH
`define TANK_LEVEL_GAUGE_FILTER_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define TLGF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is checked through reset as well.
`define TLGF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tlgf_pkg.sv =====
// Package with types and constants of the tank level gauge filter.
package tlgf_pkg;

    localparam int TANKS_DEF = 2;

    localparam logic [1:0] SEL_WATER = 2'd2;
    localparam logic [1:0] SEL_FOAM  = 2'd1;

    localparam logic [1:0] CNT_LAST    = 2'd3;
    localparam logic [7:0] PRESENT_MIN = 8'd16;
    localparam int         LEVEL_W     = 4;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 4'd8;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 4'd0;
    localparam int         GAIN_SHIFT  = 10;

    // power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] REG_WATER_MIN  = 2'd0;
    localparam logic [1:0] REG_WATER_GAIN = 2'd1;
    localparam logic [1:0] REG_FOAM_MIN   = 2'd2;
    localparam logic [1:0] REG_FOAM_GAIN  = 2'd3;

    typedef struct packed {
        logic [1:0] cnt;
        logic [9:0] sum;
        logic [7:0] filt;
    } t_entry;

    typedef struct packed {
        logic               present;
        logic [LEVEL_W-1:0] level;
        logic               tank;
    } t_result;

endpackage

// ===== rtl/tlgf_out_fifo.sv =====
// Result queue in front of the master stream port.
module tlgf_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  tlgf_pkg::t_result                   i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output tlgf_pkg::t_result                   o_data,
    output logic [tlgf_pkg::FIFO_CNT_W-1:0]     o_count
);

    tlgf_pkg::t_result r_mem [tlgf_pkg::FIFO_DEPTH];
    logic [tlgf_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [tlgf_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [tlgf_pkg::FIFO_CNT_W-1:0] r_count;
    logic pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tank_level_gauge_filter_core.sv =====
// Tank level gauge filter: per-tank boxcar average, first-order IIR, gain and clamp.
// The transaction that completes a group of 4 passes stage 1, stage 2 and the output
// queue. Throughput: one sample per cycle while tready is high; the per-tank state
// memory is read one cycle and written back the next, with forwarding between
// back-to-back samples of one tank. Reset: control and entry valid bits clear, every
// tank reads as zero, config registers reset to zero; no clearing pass.
module tank_level_gauge_filter_core #(
    parameter int TANKS = tlgf_pkg::TANKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] sample, [8] power_ok, [9] blink_phase
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] channel_select
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [3:0] level, [4] sensor_present
    output logic        o_m_axis_tuser,  // [0] tank
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (TANKS > 1) ? $clog2(TANKS) : 1;
    localparam int OCC_W = tlgf_pkg::FIFO_CNT_W + 1;

    // configuration
    logic [7:0]  r_water_min;
    logic [15:0] r_water_gain;
    logic [7:0]  r_foam_min;
    logic [15:0] r_foam_gain;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_water_min  <= '0;
            r_water_gain <= '0;
            r_foam_min   <= '0;
            r_foam_gain  <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tlgf_pkg::REG_WATER_MIN:  r_water_min  <= pwdata[7:0];
                tlgf_pkg::REG_WATER_GAIN: r_water_gain <= pwdata[15:0];
                tlgf_pkg::REG_FOAM_MIN:   r_foam_min   <= pwdata[7:0];
                tlgf_pkg::REG_FOAM_GAIN:  r_foam_gain  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tlgf_pkg::REG_WATER_MIN:  prdata = {24'd0, r_water_min};
            tlgf_pkg::REG_WATER_GAIN: prdata = {16'd0, r_water_gain};
            tlgf_pkg::REG_FOAM_MIN:   prdata = {24'd0, r_foam_min};
            tlgf_pkg::REG_FOAM_GAIN:  prdata = {16'd0, r_foam_gain};
            default:                  prdata = '0;
        endcase
    end

    // input decode
    logic             s_fire;
    logic             in_foam;
    logic             in_hit;
    logic [IDX_W-1:0] in_addr;

    assign s_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_foam = (i_s_axis_tuser == tlgf_pkg::SEL_FOAM);
    assign in_hit  = i_s_axis_tdata[8] &&
                     ((i_s_axis_tuser == tlgf_pkg::SEL_WATER) || (in_foam && (TANKS > 1)));
    assign in_addr = IDX_W'(in_foam);

    // state memory
    tlgf_pkg::t_entry r_mem [TANKS];
    logic [TANKS-1:0] r_ent_vld;
    tlgf_pkg::t_entry r_rd_data;
    logic             r_rd_vld;

    logic             r_s1_vld;
    logic [IDX_W-1:0] r_s1_addr;
    logic [7:0]       r_s1_smp;
    logic             r_s1_blink;

    logic             r_wb_vld;
    logic [IDX_W-1:0] r_wb_addr;
    tlgf_pkg::t_entry r_wb_data;

    tlgf_pkg::t_entry s1_old;
    tlgf_pkg::t_entry n_entry;
    logic [9:0]       s1_sum;
    logic [9:0]       s1_filt_acc;
    logic             s1_done;

    always_ff @(posedge i_clk) begin
        if (s_fire && in_hit) begin
            r_rd_data <= r_mem[in_addr];
            r_rd_vld  <= r_ent_vld[in_addr];
        end
        if (r_s1_vld) begin
            r_mem[r_s1_addr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_s1_vld  <= 1'b0;
            r_wb_vld  <= 1'b0;
        end else begin
            if (r_s1_vld) begin
                r_ent_vld[r_s1_addr] <= 1'b1;
            end
            r_s1_vld <= s_fire && in_hit;
            r_wb_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_addr  <= in_addr;
            r_s1_smp   <= i_s_axis_tdata[7:0];
            r_s1_blink <= i_s_axis_tdata[9];
        end
        r_wb_addr <= r_s1_addr;
        r_wb_data <= n_entry;
    end

    // read-modify-write with forwarding from the previous write
    always_comb begin
        if (r_wb_vld && (r_wb_addr == r_s1_addr)) begin
            s1_old = r_wb_data;
        end else if (r_rd_vld) begin
            s1_old = r_rd_data;
        end else begin
            s1_old = '0;
        end
        s1_sum      = s1_old.sum + {2'b00, r_s1_smp};
        s1_filt_acc = {2'b00, s1_old.filt} + {1'b0, s1_old.filt, 1'b0} + {2'b00, s1_sum[9:2]};
        s1_done     = (s1_old.cnt == tlgf_pkg::CNT_LAST);
        if (s1_done) begin
            n_entry.cnt  = '0;
            n_entry.sum  = '0;
            n_entry.filt = s1_filt_acc[9:2];
        end else begin
            n_entry.cnt  = s1_old.cnt + 2'd1;
            n_entry.sum  = s1_sum;
            n_entry.filt = s1_old.filt;
        end
    end

    // level stage
    logic       r_s2_vld;
    logic       r_s2_tank;
    logic [7:0] r_s2_filt;
    logic       r_s2_present;
    logic       r_s2_blink;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld && s1_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_tank    <= r_s1_addr[0];
        r_s2_filt    <= n_entry.filt;
        r_s2_present <= (r_s1_smp > tlgf_pkg::PRESENT_MIN);
        r_s2_blink   <= r_s1_blink;
    end

    logic [7:0]        s2_min;
    logic [15:0]       s2_gain;
    logic [7:0]        s2_diff;
    logic [23:0]       s2_prod;
    logic [13:0]       s2_raw;
    tlgf_pkg::t_result s2_res;

    always_comb begin
        s2_min  = r_s2_tank ? r_foam_min  : r_water_min;
        s2_gain = r_s2_tank ? r_foam_gain : r_water_gain;
        s2_diff = r_s2_filt - s2_min;
        s2_prod = s2_diff * s2_gain;
        s2_raw  = s2_prod[23:tlgf_pkg::GAIN_SHIFT];
        s2_res.tank    = r_s2_tank;
        s2_res.present = r_s2_present;
        if (!r_s2_present) begin
            s2_res.level = r_s2_blink ? tlgf_pkg::LEVEL_MAX : tlgf_pkg::LEVEL_ZERO;
        end else if (r_s2_filt <= s2_min) begin
            s2_res.level = tlgf_pkg::LEVEL_ZERO;
        end else if (s2_raw > 14'(tlgf_pkg::LEVEL_MAX)) begin
            s2_res.level = tlgf_pkg::LEVEL_MAX;
        end else begin
            s2_res.level = s2_raw[tlgf_pkg::LEVEL_W-1:0];
        end
    end

    // output queue; input ready reserves a slot for every item in flight
    tlgf_pkg::t_result               out_res;
    logic [tlgf_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic [OCC_W-1:0]                occ;

    tlgf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_vld),
        .i_data  (s2_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_res),
        .o_count (fifo_count)
    );

    assign occ = {1'b0, fifo_count} + OCC_W'(r_s1_vld) + OCC_W'(r_s2_vld);
    assign o_s_axis_tready = (occ < OCC_W'(tlgf_pkg::FIFO_DEPTH));

    assign o_m_axis_tdata = {3'b000, out_res.present, out_res.level};
    assign o_m_axis_tuser = out_res.tank;

endmodule

// ===== rtl/tlgf_checker.sv =====
// Port-level checker for the tank level gauge filter, bound to the top level.
`include "tank_level_gauge_filter_core_macros.svh"

module tlgf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser
);

    `TLGF_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result after reset")
    `TLGF_ASSERT_RST(a_level_range, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[3:0] <= 4'd8), "level above full")
    `TLGF_ASSERT_RST(a_absent_blink, i_clk, i_rst_n, (o_m_axis_tvalid && !o_m_axis_tdata[4]) |-> ((o_m_axis_tdata[3:0] == 4'd0) || (o_m_axis_tdata[3:0] == 4'd8)), "absent sensor level not blink")
    `TLGF_ASSERT_RST(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid |-> ((o_m_axis_tdata[7:5] == 3'd0) && (o_m_axis_tuser == 1'b0 || o_m_axis_tuser == 1'b1)), "pad bits set")
    `TLGF_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "stalled result changed")

endmodule

bind tank_level_gauge_filter_core tlgf_checker u_tlgf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
